>>> sv/wmt_pkg.sv
`default_nettype none
package wmt_pkg;

   localparam int VAL_W    = 32;
   localparam int WGT_W    = 62;
   localparam int STATUS_W = 3;
   localparam int ENTRY_W  = VAL_W + WGT_W;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_OLD_MISSING = 3'd1,
      STATUS_TABLE_FULL  = 3'd2,
      STATUS_UNDERFLOW   = 3'd3,
      STATUS_OVERFLOW    = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SUM,
      ST_CHECK,
      ST_BUILD,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

>>> sv/wmt_if.sv
`default_nettype none
// request channel: one vote update per transaction
interface wmt_req_if;
   logic                           valid;
   logic                           ready;
   logic [wmt_pkg::VAL_W-1:0]      new_value;
   logic [wmt_pkg::WGT_W-1:0]      add_weight;
   logic                           has_old;
   logic [wmt_pkg::VAL_W-1:0]      old_value;
   logic [wmt_pkg::WGT_W-1:0]      drop_weight;

   modport source (output valid, new_value, add_weight, has_old, old_value, drop_weight,
                   input ready);
   modport sink   (input valid, new_value, add_weight, has_old, old_value, drop_weight,
                   output ready);
endinterface

// response channel: median after each update
interface wmt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [wmt_pkg::VAL_W-1:0]      median;
   logic                           median_changed;
   logic [wmt_pkg::STATUS_W-1:0]   status;

   modport source (output valid, median, median_changed, status, input ready);
   modport sink   (input valid, median, median_changed, status, output ready);
endinterface
`default_nettype wire

>>> sv/weighted_median_tracker.sv
// Weighted median tracker.
// req_ch carries one vote update per transaction: weight added at new_value and,
// when has_old is set, weight withdrawn from old_value. rsp_ch returns exactly one
// transaction per update with the weighted median, a changed flag and a status.
// The sorted table lives in two banks of entry memory. An update first scans the
// current bank, then passes through a sum state and a check state, then streams the
// table into the other bank with the insert, weight changes and drops applied while
// accumulating weight for the median, and a final state commits. A rejected update
// skips the stream. req_ch.ready is high only while no update is in progress, so
// updates run one at a time. The result sits in an output register; a stalled
// rsp_ch holds it, the next update may still start, and its commit waits until the
// held result is taken. An update that fails a check leaves the table untouched.
// Reset empties the table, zeroes the total and the median, and drops any result.
`default_nettype none
module weighted_median_tracker #(
   parameter int MAX_ENTRIES = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   wmt_req_if.sink    req_ch,
   wmt_rsp_if.source  rsp_ch
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int VW = wmt_pkg::VAL_W;
   localparam int WW = wmt_pkg::WGT_W;
   localparam int EW = wmt_pkg::ENTRY_W;

   wmt_pkg::state_type state_ff, state_in;

   // latched request
   logic [VW-1:0] nv_ff, ov_ff;
   logic [WW-1:0] nw_ff, ow_ff;
   logic          ho_ff;

   // sequencing
   logic [CW-1:0] idx_ff;
   logic          pipe_ff;
   logic          ins2_ff;

   // scan results
   logic          found_new_ff, found_old_ff;
   logic [WW-1:0] w_new_ff, w_old_ff;
   logic [CW-1:0] pos_ff;

   // check results
   logic [WW-1:0] sum_nv_ff, total_add_ff;
   logic          ovf_ff;
   wmt_pkg::status_type status_ff;
   logic [WW-1:0] nv_final_ff, ov_final_ff, total_new_ff;
   logic          ins_ff, commit_ff;
   logic [CW-1:0] vcount_ff;

   // build stream
   logic          s3_valid_ff;
   logic [VW-1:0] s3_val_ff;
   logic [WW-1:0] s3_w_ff;
   logic [CW-1:0] wr_cnt_ff;
   logic [WW-1:0] cum_ff;
   logic          med_found_ff, half_ff;
   logic [VW-1:0] half_val_ff, med_work_ff;

   // architectural state
   logic          bank_ff;
   logic [CW-1:0] count_ff;
   logic [WW-1:0] total_ff;
   logic [VW-1:0] median_ff;

   // result register
   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_median_ff;
   logic          rsp_changed_ff;
   logic [wmt_pkg::STATUS_W-1:0] rsp_status_ff;

   logic          accept, issue_scan, issue_build, slot_ins, done_go;
   logic          add_c, rem_c, same_c;
   logic [IW-1:0] rd_addr;
   logic [EW-1:0] rd_data, rd0, rd1;
   logic [VW-1:0] rd_val, b_val;
   logic [WW-1:0] rd_w, b_w, wo_c, cum_sum;
   logic [WW:0]   sum_tot_c, twice, tot63;
   logic          wr_en;
   logic [VW:0]   mean_c;
   wmt_pkg::status_type status_c;

   assign accept      = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == wmt_pkg::ST_IDLE);
   assign issue_scan  = (state_ff == wmt_pkg::ST_SCAN) && (idx_ff < count_ff);
   assign issue_build = (state_ff == wmt_pkg::ST_BUILD) && (idx_ff < vcount_ff);
   assign slot_ins    = ins_ff && (idx_ff == pos_ff);
   assign done_go     = (state_ff == wmt_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign add_c  = (nw_ff != '0);
   assign rem_c  = ho_ff && (ow_ff != '0);
   assign same_c = (nv_ff == ov_ff);

   // read address: past the insert slot the old table lags by one
   always_comb begin
      if (state_ff == wmt_pkg::ST_BUILD && ins_ff && idx_ff > pos_ff) begin
         rd_addr = IW'(idx_ff - CW'(1));
      end else begin
         rd_addr = idx_ff[IW-1:0];
      end
   end

   // two banks: read the current, write the other
   wmt_ram #(.DEPTH(MAX_ENTRIES), .AW(IW), .DW(EW)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && bank_ff),
      .wr_addr (wr_cnt_ff[IW-1:0]),
      .wr_data ({s3_val_ff, s3_w_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd0)
   );

   wmt_ram #(.DEPTH(MAX_ENTRIES), .AW(IW), .DW(EW)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && !bank_ff),
      .wr_addr (wr_cnt_ff[IW-1:0]),
      .wr_data ({s3_val_ff, s3_w_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd1)
   );

   assign rd_data = bank_ff ? rd1 : rd0;
   assign rd_val  = rd_data[EW-1:WW];
   assign rd_w    = rd_data[WW-1:0];

   // checks in processing order
   assign wo_c = (add_c && same_c) ? sum_nv_ff : w_old_ff;
   always_comb begin
      priority if (add_c && ovf_ff) begin
         status_c = wmt_pkg::STATUS_OVERFLOW;
      end else if (add_c && !found_new_ff && count_ff == CW'(MAX_ENTRIES)) begin
         status_c = wmt_pkg::STATUS_TABLE_FULL;
      end else if (rem_c && !(found_old_ff || (add_c && same_c))) begin
         status_c = wmt_pkg::STATUS_OLD_MISSING;
      end else if (rem_c && wo_c < ow_ff) begin
         status_c = wmt_pkg::STATUS_UNDERFLOW;
      end else begin
         status_c = wmt_pkg::STATUS_OK;
      end
   end

   // entry as it leaves the update stage
   always_comb begin
      b_val = ins2_ff ? nv_ff : rd_val;
      priority if (ins2_ff) begin
         b_w = nv_final_ff;
      end else if (add_c && rd_val == nv_ff) begin
         b_w = nv_final_ff;
      end else if (rem_c && rd_val == ov_ff) begin
         b_w = ov_final_ff;
      end else begin
         b_w = rd_w;
      end
   end

   assign sum_tot_c = {1'b0, total_ff} + {1'b0, nw_ff};
   assign cum_sum   = cum_ff + s3_w_ff;
   assign twice     = {cum_sum, 1'b0};
   assign tot63     = {1'b0, total_new_ff};
   assign mean_c    = {1'b0, half_val_ff} + {1'b0, s3_val_ff};
   assign wr_en     = s3_valid_ff && (s3_w_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wmt_pkg::ST_IDLE:  if (accept) state_in = wmt_pkg::ST_SCAN;
         wmt_pkg::ST_SCAN:  if (idx_ff == count_ff && !pipe_ff) state_in = wmt_pkg::ST_SUM;
         wmt_pkg::ST_SUM:   state_in = wmt_pkg::ST_CHECK;
         wmt_pkg::ST_CHECK: begin
            state_in = (status_c == wmt_pkg::STATUS_OK) ? wmt_pkg::ST_BUILD : wmt_pkg::ST_DONE;
         end
         wmt_pkg::ST_BUILD: begin
            if (idx_ff == vcount_ff && !pipe_ff && !s3_valid_ff) state_in = wmt_pkg::ST_DONE;
         end
         wmt_pkg::ST_DONE:  if (done_go) state_in = wmt_pkg::ST_IDLE;
         default:           state_in = wmt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wmt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      pipe_ff <= issue_scan || issue_build;
      ins2_ff <= issue_build && slot_ins;
      if (issue_scan || issue_build) begin
         idx_ff <= idx_ff + CW'(1);
      end

      // latch request
      if (accept) begin
         nv_ff        <= req_ch.new_value;
         nw_ff        <= req_ch.add_weight;
         ho_ff        <= req_ch.has_old;
         ov_ff        <= req_ch.old_value;
         ow_ff        <= req_ch.drop_weight;
         idx_ff       <= '0;
         found_new_ff <= 1'b0;
         found_old_ff <= 1'b0;
         w_new_ff     <= '0;
         w_old_ff     <= '0;
         pos_ff       <= '0;
      end

      // scan compare
      if (state_ff == wmt_pkg::ST_SCAN && pipe_ff) begin
         if (rd_val < nv_ff) pos_ff <= pos_ff + CW'(1);
         if (rd_val == nv_ff) begin
            found_new_ff <= 1'b1;
            w_new_ff     <= rd_w;
         end
         if (rd_val == ov_ff) begin
            found_old_ff <= 1'b1;
            w_old_ff     <= rd_w;
         end
      end

      // sums
      if (state_ff == wmt_pkg::ST_SUM) begin
         sum_nv_ff    <= (found_new_ff ? w_new_ff : '0) + nw_ff;
         ovf_ff       <= sum_tot_c[WW];
         total_add_ff <= sum_tot_c[WW-1:0];
      end

      // final weights and build setup
      if (state_ff == wmt_pkg::ST_CHECK) begin
         status_ff    <= status_c;
         commit_ff    <= (status_c == wmt_pkg::STATUS_OK);
         nv_final_ff  <= sum_nv_ff - ((rem_c && same_c) ? ow_ff : '0);
         ov_final_ff  <= w_old_ff - ow_ff;
         total_new_ff <= total_add_ff - (rem_c ? ow_ff : '0);
         ins_ff       <= add_c && !found_new_ff;
         vcount_ff    <= count_ff + CW'(add_c && !found_new_ff);
         idx_ff       <= '0;
         wr_cnt_ff    <= '0;
         cum_ff       <= '0;
         med_found_ff <= 1'b0;
         half_ff      <= 1'b0;
         med_work_ff  <= median_ff;
      end

      // update stage
      s3_valid_ff <= (state_ff == wmt_pkg::ST_BUILD) && pipe_ff;
      s3_val_ff   <= b_val;
      s3_w_ff     <= b_w;

      // write back and median accumulation
      if (wr_en) begin
         wr_cnt_ff <= wr_cnt_ff + CW'(1);
         cum_ff    <= cum_sum;
         if (!med_found_ff) begin
            if (twice >= tot63) begin
               med_found_ff <= 1'b1;
               med_work_ff  <= s3_val_ff;
               half_ff      <= (twice == tot63);
               half_val_ff  <= s3_val_ff;
            end
         end else if (half_ff) begin
            med_work_ff <= mean_c[VW:1];
            half_ff     <= 1'b0;
         end
      end

      // result payload
      if (done_go) begin
         rsp_median_ff  <= commit_ff ? med_work_ff : median_ff;
         rsp_changed_ff <= commit_ff && (med_work_ff != median_ff);
         rsp_status_ff  <= status_ff;
      end
   end

   // architectural state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         count_ff     <= '0;
         total_ff     <= '0;
         median_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (done_go && commit_ff) begin
            bank_ff   <= !bank_ff;
            count_ff  <= wr_cnt_ff;
            total_ff  <= total_new_ff;
            median_ff <= med_work_ff;
         end
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.median         = rsp_median_ff;
   assign rsp_ch.median_changed = rsp_changed_ff;
   assign rsp_ch.status         = rsp_status_ff;

   // a new result only appears out of the commit state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == wmt_pkg::ST_DONE))
      else $error("result raised outside commit");

   // table never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond depth");

   // rebuild writes no more entries than it streams
   a_build_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wmt_pkg::ST_BUILD) |-> (wr_cnt_ff <= vcount_ff))
      else $error("rebuild overran stream");

   // a rejected update leaves the total alone
   a_reject_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wmt_pkg::ST_DONE && !commit_ff) |=> (total_ff == $past(total_ff)))
      else $error("rejected update changed total");

endmodule
`default_nettype wire

>>> sv/wmt_ram.sv
`default_nettype none
module wmt_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5,
   parameter int DW    = 94
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
